/* rtl/infogain_loss_gradient_unit_assert.svh */
// assertion macros, sampled on clk with arst_n low disabling them
`ifndef INFOGAIN_LOSS_GRADIENT_UNIT_ASSERT_SVH
`define INFOGAIN_LOSS_GRADIENT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define ILG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ILG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ILG_ASSERT(lbl, prop, msg)
`define ILG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/ilg_pkg.sv */
`default_nettype none

package ilg_pkg;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_ELEM   = 2'd1,
		REQ_FINISH = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		CFG_IGN_EN  = 3'd0,
		CFG_IGN_LBL = 3'd1,
		CFG_NORM    = 3'd2,
		CFG_CNT     = 3'd3,
		CFG_FLOOR   = 3'd4
	} cfg_idx_t;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [52:0] LN_RND  = 53'd2147483648;

endpackage

`default_nettype wire

/* rtl/ilg_if.sv */
`default_nettype none

interface ilg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  row_label;
	logic [7:0]  class_index;
	logic [15:0] gain_value;
	logic [15:0] prob;
	logic        last_class;
	modport source (output valid, req_type, row_label, class_index, gain_value, prob,
		last_class, input ready);
	modport sink (input valid, req_type, row_label, class_index, gain_value, prob,
		last_class, output ready);
endinterface

interface ilg_out_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic signed [31:0] gradient;
	logic [31:0]        loss_value;
	logic               error_flag;
	modport source (output valid, result_kind, gradient, loss_value, error_flag,
		input ready);
	modport sink (input valid, result_kind, gradient, loss_value, error_flag,
		output ready);
endinterface

`default_nettype wire

/* rtl/infogain_loss_gradient_unit.sv */
// channel   dir  word
// in_ch     in   req_type, row_label, class_index, gain_value, prob, last_class
// out_ch    out  result_kind, gradient, loss_value, error_flag
// cfg_*     in   write enable, register index, 16-bit data
//
// one word at a time; a load reads the row sum, then writes it back in S_LDWR
// an element is dominated by the 16 squaring steps of the log unit
// a finish with a nonzero divisor is dominated by the one-bit-per-cycle 48-bit divider
// row sums read as zero after reset through per-row valid bits; no clearing pass
// a finished word waits in the output register while the next word is taken
`default_nettype none

`include "infogain_loss_gradient_unit_assert.svh"

module infogain_loss_gradient_unit #(
	parameter int NUM_CLASSES    = 32,
	parameter int LOG_TABLE_BITS = 10
) (
	input  wire         clk,
	input  wire         arst_n,
	ilg_in_if.sink      in_ch,
	ilg_out_if.source   out_ch,
	input  wire         cfg_we,
	input  wire [2:0]   cfg_idx,
	input  wire [15:0]  cfg_wdata
);

	localparam int RW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int DEPTH = NUM_CLASSES * NUM_CLASSES;
	localparam int AW    = $clog2(DEPTH);
	localparam int FSH   = 15 - LOG_TABLE_BITS;
	localparam logic [15:0] MQ_MASK = 16'(16'hFFFF << FSH);
	localparam logic [AW-1:0] NC_A  = AW'(NUM_CLASSES);
	localparam logic [8:0] NC_9     = 9'(NUM_CLASSES);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_LDWR = 8'b0000_0010,
		S_LOG  = 8'b0000_0100,
		S_LN   = 8'b0000_1000,
		S_TERM = 8'b0001_0000,
		S_ACC  = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic        cfg_ign_en_q;
	logic [7:0]  cfg_ign_lbl_q;
	logic        cfg_norm_q;
	logic [15:0] cfg_cnt_q;
	logic [15:0] cfg_floor_q;

	logic [47:0] acc_q;
	logic [31:0] pix_q;
	logic [3:0]  log_k_q;
	logic [5:0]  div_k_q;
	logic        out_vld_q;

	logic [15:0] gain_mem [DEPTH];
	logic [23:0] rs_mem [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] rs_vld_q;
	logic [15:0] g_rd_q;
	logic [23:0] rs_rd_q;
	logic        rsv_rd_q;

	logic [RW-1:0] row_q;
	logic [AW-1:0] addr_q;
	logic [15:0]   gval_q;
	logic [15:0]   prob_q;
	logic [3:0]    e_q;
	logic [30:0]   x_q;
	logic [15:0]   frac_q;
	logic [39:0]   prod_q;
	logic [20:0]   nl_q;
	logic [28:0]   term_q;
	logic [31:0]   grad_q;
	logic [47:0]   dq_q;
	logic [31:0]   rem_q;
	logic [31:0]   dvs_q;

	logic        res_kind_q;
	logic [31:0] res_grad_q;
	logic [31:0] res_loss_q;
	logic        res_err_q;
	logic        out_kind_q;
	logic [31:0] out_grad_q;
	logic [31:0] out_loss_q;
	logic        out_err_q;

	logic          accept, out_free;
	logic          row_ok, cls_ok, ign;
	logic          gain_re, rs_re, load_ok;
	logic [AW-1:0] in_addr;
	logic [RW-1:0] in_row;
	logic [15:0]   fl, p, mn;
	logic [3:0]    lz_e;
	logic [30:0]   x0;
	logic [61:0]   sq;
	logic [31:0]   y;
	logic [30:0]   x_nx;
	logic [23:0]   rs_eff;
	logic [24:0]   rs_sum;
	logic [23:0]   rs_new;
	logic [20:0]   nl2;
	logic [52:0]   nl_full;
	logic [36:0]   tprod;
	logic [32:0]   gd;
	logic [31:0]   grad_sat;
	logic [48:0]   acc_sum;
	logic [31:0]   div_sel;
	logic [32:0]   r2;
	logic [31:0]   rem_nx;
	logic [47:0]   dq_nx;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !out_vld_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);

	assign row_ok  = {1'b0, in_ch.row_label} < NC_9;
	assign cls_ok  = {1'b0, in_ch.class_index} < NC_9;
	assign ign     = cfg_ign_en_q && (in_ch.row_label == cfg_ign_lbl_q);
	assign in_row  = in_ch.row_label[RW-1:0];
	assign in_addr = AW'(AW'(in_row) * NC_A + AW'(in_ch.class_index[RW-1:0]));
	assign load_ok = (in_ch.req_type == ilg_pkg::REQ_LOAD) && row_ok && cls_ok;
	assign gain_re = accept && (in_ch.req_type == ilg_pkg::REQ_ELEM) && !ign
		&& row_ok && cls_ok;
	assign rs_re   = gain_re || (accept && load_ok);

	assign fl = (cfg_floor_q == 16'd0) ? 16'd1 : cfg_floor_q;
	assign p  = (in_ch.prob > fl) ? in_ch.prob : fl;

	always_comb begin
		lz_e = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (p[i]) lz_e = 4'(i);
		end
	end

	assign mn = p << (4'd15 - lz_e);
	assign x0 = {mn & MQ_MASK, 15'b0};

	assign sq   = 62'(x_q) * 62'(x_q);
	assign y    = sq[61:30];
	assign x_nx = y[31] ? y[31:1] : y[30:0];

	assign rs_eff = rsv_rd_q ? rs_rd_q : 24'd0;
	assign rs_sum = {1'b0, rs_eff} + 25'(gval_q);
	assign rs_new = rs_sum[24] ? 24'hFF_FFFF : rs_sum[23:0];

	assign nl2     = {5'(5'd16 - 5'(e_q)), 16'b0} - 21'(frac_q);
	assign nl_full = 53'(nl2) * 53'(ilg_pkg::LN2_Q32) + ilg_pkg::LN_RND;
	assign tprod   = 37'(g_rd_q) * 37'(nl_q);
	assign gd      = {1'b0, prod_q[39:8]} - 33'({g_rd_q, 8'b0});
	assign grad_sat = (!gd[32] && gd[31]) ? 32'h7FFF_FFFF : gd[31:0];
	assign acc_sum = {1'b0, acc_q} + 49'(term_q);

	assign div_sel = cfg_norm_q ? pix_q : {16'b0, cfg_cnt_q};
	assign r2      = {rem_q, dq_q[47]};
	always_comb begin
		if (r2 >= {1'b0, dvs_q}) begin
			rem_nx = 32'(r2 - {1'b0, dvs_q});
			dq_nx  = {dq_q[46:0], 1'b1};
		end else begin
			rem_nx = r2[31:0];
			dq_nx  = {dq_q[46:0], 1'b0};
		end
	end

	// gain matrix and row sums
	always_ff @(posedge clk) begin
		if (state_q == S_LDWR) begin
			gain_mem[addr_q] <= gval_q;
			rs_mem[row_q]    <= rs_new;
		end
		if (gain_re) g_rd_q <= gain_mem[in_addr];
		if (rs_re) rs_rd_q <= rs_mem[in_row];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_vld_q <= '0;
			rsv_rd_q <= 1'b0;
		end else begin
			if (state_q == S_LDWR) rs_vld_q[row_q] <= 1'b1;
			if (rs_re) rsv_rd_q <= rs_vld_q[in_row];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q  <= in_row;
			addr_q <= in_addr;
			gval_q <= in_ch.gain_value;
			prob_q <= in_ch.prob;
			e_q    <= lz_e;
			x_q    <= x0;
			frac_q <= '0;
			dq_q   <= acc_q;
			rem_q  <= '0;
			dvs_q  <= div_sel;
			res_grad_q <= '0;
			res_loss_q <= '0;
			res_kind_q <= (in_ch.req_type == ilg_pkg::REQ_FINISH);
			res_err_q  <= (in_ch.req_type == ilg_pkg::REQ_FINISH) ? 1'b1 : !ign;
		end
		if (state_q == S_LOG) begin
			x_q    <= x_nx;
			frac_q <= {frac_q[14:0], y[31]};
			prod_q <= 40'(prob_q) * 40'(rs_eff);
		end
		if (state_q == S_LN) nl_q <= nl_full[52:32];
		if (state_q == S_TERM) begin
			term_q <= tprod[36:8];
			grad_q <= grad_sat;
		end
		if (state_q == S_ACC) begin
			res_kind_q <= 1'b0;
			res_grad_q <= grad_q;
			res_loss_q <= '0;
			res_err_q  <= 1'b0;
		end
		if (state_q == S_DIV) begin
			rem_q <= rem_nx;
			dq_q  <= dq_nx;
			if (div_k_q == 6'd47) begin
				res_loss_q <= (dq_nx[47:32] != 16'd0) ? 32'hFFFF_FFFF : dq_nx[31:0];
				res_err_q  <= 1'b0;
			end
		end
		if (state_q == S_OUT && out_free) begin
			out_kind_q <= res_kind_q;
			out_grad_q <= res_grad_q;
			out_loss_q <= res_loss_q;
			out_err_q  <= res_err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cfg_ign_en_q  <= 1'b0;
			cfg_ign_lbl_q <= 8'd255;
			cfg_norm_q    <= 1'b1;
			cfg_cnt_q     <= 16'd1;
			cfg_floor_q   <= 16'd1;
			acc_q         <= '0;
			pix_q         <= '0;
			log_k_q       <= '0;
			div_k_q       <= '0;
			out_vld_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					ilg_pkg::CFG_IGN_EN:  cfg_ign_en_q  <= cfg_wdata[0];
					ilg_pkg::CFG_IGN_LBL: cfg_ign_lbl_q <= cfg_wdata[7:0];
					ilg_pkg::CFG_NORM:    cfg_norm_q    <= cfg_wdata[0];
					ilg_pkg::CFG_CNT:     cfg_cnt_q     <= cfg_wdata;
					ilg_pkg::CFG_FLOOR:   cfg_floor_q   <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == S_OUT && out_free) out_vld_q <= 1'b1;
			else if (out_ch.ready) out_vld_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					log_k_q <= '0;
					div_k_q <= '0;
					if (accept) begin
						unique case (in_ch.req_type)
							ilg_pkg::REQ_LOAD: begin
								if (load_ok) state_q <= S_LDWR;
							end
							ilg_pkg::REQ_ELEM: begin
								state_q <= gain_re ? S_LOG : S_OUT;
								if (!ign && row_ok && in_ch.last_class
									&& pix_q != 32'hFFFF_FFFF) begin
									pix_q <= pix_q + 32'd1;
								end
							end
							ilg_pkg::REQ_FINISH: begin
								state_q <= (div_sel == 32'd0) ? S_OUT : S_DIV;
								acc_q   <= '0;
								pix_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				S_LDWR: state_q <= S_IDLE;
				S_LOG: begin
					log_k_q <= log_k_q + 4'd1;
					if (log_k_q == 4'd15) state_q <= S_LN;
				end
				S_LN:   state_q <= S_TERM;
				S_TERM: state_q <= S_ACC;
				S_ACC: begin
					acc_q   <= acc_sum[48] ? 48'hFFFF_FFFF_FFFF : acc_sum[47:0];
					state_q <= S_OUT;
				end
				S_DIV: begin
					div_k_q <= div_k_q + 6'd1;
					if (div_k_q == 6'd47) state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_vld_q;
	assign out_ch.result_kind = out_kind_q;
	assign out_ch.gradient    = $signed(out_grad_q);
	assign out_ch.loss_value  = out_loss_q;
	assign out_ch.error_flag  = out_err_q;

	`ILG_ASSERT_NEXT(a_fin_clear, accept && in_ch.req_type == ilg_pkg::REQ_FINISH, acc_q == 48'd0 && pix_q == 32'd0, "finish did not clear accumulator")
	`ILG_ASSERT_NEXT(a_out_load, state_q == S_OUT && out_free, out_vld_q, "result not presented")
	`ILG_ASSERT_NEXT(a_rs_valid, state_q == S_LDWR, rs_vld_q[$past(row_q)], "row sum valid not set")

endmodule

`default_nettype wire

/* sim/ilg_tb_if.sv */
`timescale 1ns / 1ps

package ilg_tb_pkg;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  row_label;
		logic [7:0]  class_index;
		logic [15:0] gain_value;
		logic [15:0] prob;
		logic        last_class;
	} in_word_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [31:0] gradient;
		logic [31:0]        loss_value;
		logic               error_flag;
	} out_word_t;
endpackage

/* sim/tb_infogain_loss_gradient_unit.sv */
`timescale 1ns / 1ps

module tb_infogain_loss_gradient_unit;

	localparam int NCLS = 32;
	localparam int LTB = 10;
	localparam int WD_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_idx;
	logic [15:0] cfg_wdata;

	ilg_in_if in_ch();
	ilg_out_if out_ch();

	infogain_loss_gradient_unit #(.NUM_CLASSES(NCLS), .LOG_TABLE_BITS(LTB)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	typedef struct {
		ilg_tb_pkg::in_word_t  w;
		bit                    fixed;
		ilg_tb_pkg::out_word_t r;
	} stim_row_t;

	// predictor state
	logic [15:0] gain_mem [NCLS*NCLS];
	bit          gain_written [NCLS*NCLS];
	logic [23:0] row_total [NCLS];
	logic [47:0] loss_sum;
	logic [31:0] pix_cnt;
	logic        ign_en;
	logic [7:0]  ign_lbl;
	logic        norm_on;
	logic [15:0] cases;
	logic [15:0] prob_floor;

	ilg_tb_pkg::out_word_t pending_results[$];
	stim_row_t stim_rows[$];
	bit failed;
	int send_idle_pct, recv_idle_pct;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void queue_result(input ilg_tb_pkg::out_word_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void add_row(input ilg_tb_pkg::in_word_t w, input bit fixed,
		input ilg_tb_pkg::out_word_t r);
		stim_row_t sr;
		sr.w = w;
		sr.fixed = fixed;
		sr.r = r;
		stim_rows.insert(stim_rows.size(), sr);
	endfunction

	function automatic logic [63:0] neg_ln(input logic [15:0] p);
		int e;
		logic [15:0] m;
		logic [31:0] idx, mq;
		logic [63:0] x, nl2;
		logic [31:0] frac;
		logic [127:0] prod;
		e = 15;
		frac = 0;
		while (e > 0 && p[e] == 1'b0)
			e--;
		m = 16'((32'(p) << (15 - e)));
		idx = (32'(m) - 32768) >> (15 - LTB);
		mq = 32768 + (idx << (15 - LTB));
		x = 64'(mq) << 15;
		for (int k = 0; k < 16; k++) begin
			x = (x * x) >> 30;
			frac = frac << 1;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				frac[0] = 1'b1;
			end
		end
		nl2 = 64'(16 - e) * 65536 - 64'(frac);
		prod = 128'(nl2) * 128'(ilg_pkg::LN2_Q32) + (128'd1 << 31);
		return 64'(prod >> 32);
	endfunction

	function automatic void reset_predictor();
		foreach (gain_mem[i]) begin
			gain_mem[i] = '0;
			gain_written[i] = 1'b0;
		end
		foreach (row_total[i])
			row_total[i] = '0;
		loss_sum = '0;
		pix_cnt = '0;
		ign_en = 1'b0;
		ign_lbl = 8'd255;
		norm_on = 1'b1;
		cases = 16'd1;
		prob_floor = 16'd1;
	endfunction

	// advance the predictor by one accepted word
	function automatic void predict_word(input ilg_tb_pkg::in_word_t w);
		ilg_tb_pkg::out_word_t r;
		logic [24:0] s;
		logic [15:0] g, fl, p;
		logic [63:0] term, q, dv;
		longint grad;
		r = '0;
		case (w.req_type)
			ilg_pkg::REQ_LOAD: begin
				if (w.row_label < NCLS && w.class_index < NCLS) begin
					s = 25'(row_total[w.row_label]) + 25'(w.gain_value);
					gain_mem[w.row_label*NCLS + w.class_index] = w.gain_value;
					gain_written[w.row_label*NCLS + w.class_index] = 1'b1;
					row_total[w.row_label] = s > 25'hFFFFFF ? 24'hFFFFFF : s[23:0];
				end
			end
			ilg_pkg::REQ_ELEM: begin
				grad = 0;
				if (ign_en && w.row_label == ign_lbl) begin
					grad = 0;
				end else if (w.row_label >= NCLS) begin
					r.error_flag = 1'b1;
				end else begin
					if (w.class_index >= NCLS) begin
						r.error_flag = 1'b1;
					end else begin
						g = gain_mem[w.row_label*NCLS + w.class_index];
						fl = prob_floor != 0 ? prob_floor : 16'd1;
						p = w.prob > fl ? w.prob : fl;
						term = (64'(g) * neg_ln(p)) >> 8;
						grad = longint'((64'(w.prob) * 64'(row_total[w.row_label])) >> 8)
							- longint'(64'(g) << 8);
						if (grad > 64'sd2147483647)
							grad = 64'sd2147483647;
						q = 64'(loss_sum) + term;
						loss_sum = q > 64'hFFFFFFFFFFFF ? 48'hFFFFFFFFFFFF : q[47:0];
					end
					if (w.last_class && pix_cnt != 32'hFFFFFFFF)
						pix_cnt++;
				end
				r.result_kind = 1'b0;
				r.gradient = 32'(grad);
				queue_result(r);
			end
			ilg_pkg::REQ_FINISH: begin
				dv = norm_on ? 64'(pix_cnt) : 64'(cases);
				r.result_kind = 1'b1;
				if (dv == 0) begin
					r.error_flag = 1'b1;
				end else begin
					q = 64'(loss_sum) / dv;
					r.loss_value = q > 64'hFFFFFFFF ? 32'hFFFFFFFF : q[31:0];
				end
				loss_sum = '0;
				pix_cnt = '0;
				queue_result(r);
			end
			default: ;
		endcase
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		ilg_tb_pkg::out_word_t got, want;
		if (out_ch.valid && out_ch.ready) begin
			got = '{out_ch.result_kind, out_ch.gradient, out_ch.loss_value,
				out_ch.error_flag};
			if (pending_results.size() == 0) begin
				$display("%0t unexpected word kind=%0d grad=%0d loss=%0d err=%0d", $time,
					got.result_kind, got.gradient, got.loss_value, got.error_flag);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (got.result_kind !== want.result_kind) begin
					$display("%0t result_kind exp %0d got %0d", $time,
						want.result_kind, got.result_kind);
					failed = 1'b1;
				end
				if (got.gradient !== want.gradient) begin
					$display("%0t gradient exp %0d got %0d", $time,
						want.gradient, got.gradient);
					failed = 1'b1;
				end
				if (got.loss_value !== want.loss_value) begin
					$display("%0t loss_value exp %0d got %0d", $time,
						want.loss_value, got.loss_value);
					failed = 1'b1;
				end
				if (got.error_flag !== want.error_flag) begin
					$display("%0t error_flag exp %0d got %0d", $time,
						want.error_flag, got.error_flag);
					failed = 1'b1;
				end
			end
		end
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles without any accepted input or output word
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("tb_infogain_loss_gradient_unit NOT OK");
			$finish;
		end
	end

	task automatic write_reg(input ilg_pkg::cfg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ilg_pkg::CFG_IGN_EN:  ign_en = val[0];
			ilg_pkg::CFG_IGN_LBL: ign_lbl = val[7:0];
			ilg_pkg::CFG_NORM:    norm_on = val[0];
			ilg_pkg::CFG_CNT:     cases = val;
			ilg_pkg::CFG_FLOOR:   prob_floor = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// wait until every expected result is back, then let a load finish
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_word(input ilg_tb_pkg::in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		{in_ch.req_type, in_ch.row_label, in_ch.class_index, in_ch.gain_value,
			in_ch.prob, in_ch.last_class} <= w;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_word(w);
	endtask

	function automatic ilg_tb_pkg::in_word_t mk(input logic [1:0] rq, input int row,
		input int cls, input int gv, input int pr, input bit last);
		return '{rq, 8'(row), 8'(cls), 16'(gv), 16'(pr), last};
	endfunction

	// random element on a written cell, a load on an unwritten one, or noise
	task automatic random_word();
		ilg_tb_pkg::in_word_t w;
		int row, cls, sel;
		w = '{2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			16'($urandom), 16'($urandom), 1'($urandom_range(1))};
		sel = $urandom_range(99);
		if (sel < 70) begin
			row = $urandom_range(NCLS-1);
			cls = $urandom_range(NCLS-1);
			if (!gain_written[row*NCLS + cls]) begin
				w = mk(ilg_pkg::REQ_LOAD, row, cls, int'($urandom), 0, 1'b0);
			end else begin
				w.req_type = ilg_pkg::REQ_ELEM;
				w.row_label = 8'(row);
				w.class_index = 8'(cls);
				if ($urandom_range(3) == 0)
					w.prob = 16'($urandom_range(3));
			end
		end else if (sel < 80) begin
			w.req_type = ilg_pkg::REQ_FINISH;
		end else if (sel < 88) begin
			w.req_type = ilg_pkg::REQ_LOAD;
		end else if (w.req_type == ilg_pkg::REQ_ELEM && w.row_label < NCLS
			&& w.class_index < NCLS
			&& !(ign_en && w.row_label == ign_lbl)
			&& !gain_written[w.row_label*NCLS + w.class_index]) begin
			w.class_index = 8'(NCLS + $urandom_range(255 - NCLS));
		end
		send_word(w);
	endtask

	initial begin
		failed = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = ilg_pkg::CFG_IGN_EN;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		{in_ch.req_type, in_ch.row_label, in_ch.class_index, in_ch.gain_value,
			in_ch.prob, in_ch.last_class} = '0;
		out_ch.ready = 1'b0;
		reset_predictor();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		add_row(mk(ilg_pkg::REQ_FINISH, 0, 0, 0, 0, 1'b0), 1'b1,
			'{1'b1, 32'sd0, 32'd0, 1'b1});
		add_row(mk(ilg_pkg::REQ_LOAD, 0, 0, 16'hFFFF, 0, 1'b0), 1'b0, '0);
		add_row(mk(ilg_pkg::REQ_LOAD, 0, 1, 16'h0100, 0, 1'b0), 1'b0, '0);
		add_row(mk(ilg_pkg::REQ_LOAD, 0, 1, 16'h0200, 0, 1'b0), 1'b0, '0);
		add_row(mk(ilg_pkg::REQ_LOAD, 31, 31, 0, 0, 1'b0), 1'b0, '0);
		add_row(mk(ilg_pkg::REQ_LOAD, 32, 0, 5, 0, 1'b0), 1'b0, '0);
		add_row(mk(ilg_pkg::REQ_LOAD, 0, 255, 5, 0, 1'b0), 1'b0, '0);
		add_row(mk(ilg_pkg::REQ_ELEM, 0, 0, 0, 0, 1'b0), 1'b0, '0);
		add_row(mk(ilg_pkg::REQ_ELEM, 0, 0, 0, 16'hFFFF, 1'b0), 1'b0, '0);
		add_row(mk(ilg_pkg::REQ_ELEM, 0, 1, 0, 16'h8000, 1'b1), 1'b0, '0);
		add_row(mk(ilg_pkg::REQ_ELEM, 31, 31, 0, 1, 1'b1), 1'b0, '0);
		add_row(mk(ilg_pkg::REQ_ELEM, 255, 0, 0, 100, 1'b1), 1'b1,
			'{1'b0, 32'sd0, 32'd0, 1'b1});
		add_row(mk(ilg_pkg::REQ_ELEM, 0, 200, 0, 100, 1'b1), 1'b1,
			'{1'b0, 32'sd0, 32'd0, 1'b1});
		add_row(mk(2'd3, 0, 0, 0, 0, 1'b0), 1'b0, '0);
		add_row(mk(ilg_pkg::REQ_FINISH, 0, 0, 0, 0, 1'b0), 1'b0, '0);
		add_row(mk(ilg_pkg::REQ_FINISH, 0, 0, 0, 0, 1'b0), 1'b1,
			'{1'b1, 32'sd0, 32'd0, 1'b1});
		foreach (stim_rows[i]) begin
			if (stim_rows[i].fixed)
				stim_rows[i].r.result_kind = stim_rows[i].w.req_type == ilg_pkg::REQ_FINISH;
			send_word(stim_rows[i].w);
			if (stim_rows[i].fixed)
				pending_results[pending_results.size()-1] = stim_rows[i].r;
		end
		drain();

		// ignored label, case count divisor and probability floor
		write_reg(ilg_pkg::CFG_IGN_EN, 16'd1);
		write_reg(ilg_pkg::CFG_IGN_LBL, 16'd0);
		write_reg(ilg_pkg::CFG_NORM, 16'd0);
		write_reg(ilg_pkg::CFG_CNT, 16'd65535);
		write_reg(ilg_pkg::CFG_FLOOR, 16'hFFFF);
		send_word(mk(ilg_pkg::REQ_ELEM, 0, 0, 0, 16'h1234, 1'b1));
		send_word(mk(ilg_pkg::REQ_ELEM, 255, 0, 0, 16'h1234, 1'b1));
		send_word(mk(ilg_pkg::REQ_ELEM, 31, 31, 0, 16'h0, 1'b1));
		send_word(mk(ilg_pkg::REQ_FINISH, 0, 0, 0, 0, 1'b0));
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 31 : (ph == 1 ? 67 : 0);
			recv_idle_pct = ph == 0 ? 67 : (ph == 1 ? 31 : 0);
			for (int c = 0; c < 3; c++) begin
				write_reg(ilg_pkg::CFG_IGN_EN, 16'($urandom_range(1)));
				write_reg(ilg_pkg::CFG_IGN_LBL,
					c == 0 ? 16'd255 : 16'($urandom_range(40)));
				write_reg(ilg_pkg::CFG_NORM, 16'($urandom_range(1)));
				write_reg(ilg_pkg::CFG_CNT,
					c == 1 ? 16'd1 : 16'($urandom_range(1, 65535)));
				write_reg(ilg_pkg::CFG_FLOOR,
					c == 2 ? 16'hFFFF : 16'($urandom_range(1, 4000)));
				for (int n = 0; n < 155; n++) begin
					random_word();
					if (n == 77 && c == 0)
						drain();
				end
				drain();
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (!failed)
			$display("tb_infogain_loss_gradient_unit OK");
		else
			$display("tb_infogain_loss_gradient_unit NOT OK");
		$finish;
	end
endmodule
